// ===== hw/rtl/dlbs_pkg.sv =====
// Package with the shared types and constants of the decimal limb subtractor.
package dlbs_pkg;

  localparam int unsigned LIMB_W    = 64;
  localparam int unsigned MAX_LIMBS = 64;
  localparam int unsigned IDX_W     = $clog2(MAX_LIMBS);
  localparam int unsigned CNT_W     = $clog2(MAX_LIMBS + 1);
  localparam int unsigned LEN_W     = 7;

  localparam logic [LIMB_W-1:0] LIMB_BASE = 64'd10000000000000000000;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Operands handed to the shared subtractor.
  typedef struct packed {
    limb_t x;
    limb_t y;
    logic  bin;
  } unit_op_t;

  // What the shared subtractor gives back.
  typedef struct packed {
    limb_t diff;
    logic  need;
    logic  raw_zero;
    logic  diff_zero;
  } unit_res_t;

  // Store access commands from the sequencer.
  typedef struct packed {
    logic op_we;
    idx_t op_waddr;
    idx_t rd_addr;
    logic diff_we;
    idx_t diff_waddr;
  } mem_ctrl_t;

  // Result side status from the sequencer.
  typedef struct packed {
    logic             busy;
    logic             valid;
    logic             last;
    logic             negative;
    logic [LEN_W-1:0] length;
  } out_stat_t;

endpackage

// ===== hw/rtl/dlbs_sub_unit.sv =====
// Shared limb subtractor with borrow and base 10^19 correction.
module dlbs_sub_unit
  import dlbs_pkg::*;
(
  input  unit_op_t  op_i,
  output unit_res_t res_o
);

  logic [LIMB_W:0] raw;
  limb_t           corr;

  // The top bit of the extended difference is the borrow out.
  assign raw  = {1'b0, op_i.x} - {1'b0, op_i.y} - {{LIMB_W{1'b0}}, op_i.bin};
  assign corr = raw[LIMB_W-1:0] + (raw[LIMB_W] ? LIMB_BASE : '0);

  assign res_o.diff      = corr;
  assign res_o.need      = raw[LIMB_W];
  assign res_o.raw_zero  = (raw[LIMB_W-1:0] == '0) && !raw[LIMB_W];
  assign res_o.diff_zero = (corr == '0);

endmodule

// ===== hw/rtl/dlbs_limb_store.sv =====
// Operand and difference limb memories with registered read data.
module dlbs_limb_store
  import dlbs_pkg::*;
(
  input  logic      clk_i,
  input  mem_ctrl_t ctrl_i,
  input  limb_t     a_wdata_i,
  input  limb_t     b_wdata_i,
  input  limb_t     diff_wdata_i,
  output limb_t     a_rdata_o,
  output limb_t     b_rdata_o,
  output limb_t     diff_rdata_o
);

  limb_t a_mem    [MAX_LIMBS];
  limb_t b_mem    [MAX_LIMBS];
  limb_t diff_mem [MAX_LIMBS];
  limb_t a_rd_q, b_rd_q, diff_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op_we) begin
      a_mem[ctrl_i.op_waddr] <= a_wdata_i;
      b_mem[ctrl_i.op_waddr] <= b_wdata_i;
    end
    if (ctrl_i.diff_we) begin
      diff_mem[ctrl_i.diff_waddr] <= diff_wdata_i;
    end
    a_rd_q    <= a_mem[ctrl_i.rd_addr];
    b_rd_q    <= b_mem[ctrl_i.rd_addr];
    diff_rd_q <= diff_mem[ctrl_i.rd_addr];
  end

  assign a_rdata_o    = a_rd_q;
  assign b_rdata_o    = b_rd_q;
  assign diff_rdata_o = diff_rd_q;

endmodule

// ===== hw/rtl/dlbs_ctrl.sv =====
// Sequencer for load, compare, borrow ripple and result emission.
module dlbs_ctrl
  import dlbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      last_limb_i,
  input  limb_t     a_rd_i,
  input  limb_t     b_rd_i,
  input  unit_res_t unit_res_i,
  output unit_op_t  unit_op_o,
  output mem_ctrl_t mem_ctrl_o,
  output out_stat_t stat_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CPREP = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_SUB   = 3'd3;
  localparam logic [2:0] ST_EPREP = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;
  cnt_t       cnt_q, cnt_d;
  cnt_t       n_q, n_d;
  idx_t       k_q, k_d;
  idx_t       start_q, start_d;
  logic       borrow_q, borrow_d;
  logic       swap_q, swap_d;

  logic       full;
  logic       use_swap;
  idx_t       top_idx;
  cnt_t       len;

  assign full     = (cnt_q >= cnt_t'(MAX_LIMBS));
  assign top_idx  = idx_t'(n_q - cnt_t'(1));
  assign use_swap = (state_q == ST_SUB) && swap_q;
  assign len      = n_q - cnt_t'(start_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    k_d      = k_q;
    start_d  = start_q;
    borrow_d = borrow_q;
    swap_d   = swap_q;
    mem_ctrl_o = '0;
    mem_ctrl_o.op_waddr   = idx_t'(cnt_q);
    mem_ctrl_o.diff_waddr = k_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (!full) begin
            mem_ctrl_o.op_we = 1'b1;
          end
          if (last_limb_i) begin
            n_d     = full ? cnt_q : cnt_q + cnt_t'(1);
            k_d     = '0;
            state_d = ST_CPREP;
          end else if (!full) begin
            cnt_d = cnt_q + cnt_t'(1);
          end
        end
      end
      ST_CPREP: begin
        // Lets the final pair settle in the store before it is read.
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (unit_res_i.need || !unit_res_i.raw_zero || (k_q == top_idx)) begin
          swap_d   = unit_res_i.need;
          borrow_d = 1'b0;
          start_d  = top_idx;
          k_d      = top_idx;
          state_d  = ST_SUB;
        end else begin
          k_d = k_q + idx_t'(1);
        end
      end
      ST_SUB: begin
        mem_ctrl_o.diff_we = 1'b1;
        borrow_d = unit_res_i.need;
        if (!unit_res_i.diff_zero) begin
          start_d = k_q;
        end
        if (k_q == '0) begin
          state_d = ST_EPREP;
        end else begin
          k_d = k_q - idx_t'(1);
        end
      end
      ST_EPREP: begin
        k_d     = start_q;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (k_q == top_idx) begin
          cnt_d    = '0;
          borrow_d = 1'b0;
          state_d  = ST_IDLE;
        end else begin
          k_d = k_q + idx_t'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    mem_ctrl_o.rd_addr = k_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      n_q      <= '0;
      k_q      <= '0;
      start_q  <= '0;
      borrow_q <= 1'b0;
      swap_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      k_q      <= k_d;
      start_q  <= start_d;
      borrow_q <= borrow_d;
      swap_q   <= swap_d;
    end
  end

  // The compare pass always takes the operands in their arrival order.
  assign unit_op_o.x   = use_swap ? b_rd_i : a_rd_i;
  assign unit_op_o.y   = use_swap ? a_rd_i : b_rd_i;
  assign unit_op_o.bin = (state_q == ST_SUB) && borrow_q;

  assign stat_o.busy     = (state_q != ST_IDLE);
  assign stat_o.valid    = (state_q == ST_EMIT);
  assign stat_o.last     = (state_q == ST_EMIT) && (k_q == top_idx);
  assign stat_o.negative = swap_q;
  assign stat_o.length   = LEN_W'(len);

endmodule

// ===== hw/rtl/decimal_limb_bignum_subtract_unit.sv =====
// Top level of the base 10^19 multiprecision subtractor.
//
// Usage and timing: an item is one pair of limbs (a_limb_i, b_limb_i), most
// significant pair first, taken when start is high and busy is low. Pairs
// without last_limb_i are stored and leave busy low, so a whole operand
// streams in at one pair per cycle. The pair flagged last_limb_i starts the
// work and raises busy. After a state that lets the last pair settle in the
// limb memories, the block compares the two numbers from the top limb down
// to the first limb that differs or to the least significant one, subtracts
// with a borrow ripple from the least significant limb up, and after a
// set-up state puts the magnitude of the difference out most significant
// limb first, one limb per cycle, with leading zero limbs stripped. Busy
// stays high through the last item of the answer. The single read port of
// the limb memories and the one shared 64-bit subtractor serve both the
// compare and the ripple pass, one limb per cycle. Each emitted limb is on
// the result ports for exactly one cycle, marked by valid_o; the receiver
// cannot stall the block and must take every item as it appears. negative_o
// says the first operand was the smaller one, result_length_o holds the
// stripped length on every item of an answer, and end_of_result_o marks the
// last item. An all-zero difference gives one zero limb. Pairs beyond the
// memory depth are dropped, but a last flag on a dropped pair still starts
// the work on what was stored. There is no clearing pass after reset: the
// memories are only ever read where the current operands wrote.
module decimal_limb_bignum_subtract_unit
  import dlbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [63:0]      a_limb_i,
  input  logic [63:0]      b_limb_i,
  input  logic             last_limb_i,
  output logic             valid_o,
  output logic [63:0]      diff_limb_o,
  output logic             negative_o,
  output logic [LEN_W-1:0] result_length_o,
  output logic             end_of_result_o
);

  mem_ctrl_t mem_ctrl;
  unit_op_t  unit_op;
  unit_res_t unit_res;
  out_stat_t stat;
  limb_t     a_rd, b_rd, diff_rd;

  // The sequencer owns all control state and steers the shared subtractor.
  dlbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .last_limb_i(last_limb_i),
    .a_rd_i     (a_rd),
    .b_rd_i     (b_rd),
    .unit_res_i (unit_res),
    .unit_op_o  (unit_op),
    .mem_ctrl_o (mem_ctrl),
    .stat_o     (stat)
  );

  // One subtractor serves both the magnitude compare and the borrow ripple.
  dlbs_sub_unit u_sub (
    .op_i (unit_op),
    .res_o(unit_res)
  );

  // The difference memory is written straight from the subtractor result.
  dlbs_limb_store u_store (
    .clk_i       (clk_i),
    .ctrl_i      (mem_ctrl),
    .a_wdata_i   (a_limb_i),
    .b_wdata_i   (b_limb_i),
    .diff_wdata_i(unit_res.diff),
    .a_rdata_o   (a_rd),
    .b_rdata_o   (b_rd),
    .diff_rdata_o(diff_rd)
  );

  // Result limbs come from the registered read port of the difference memory.
  assign busy            = stat.busy;
  assign valid_o         = stat.valid;
  assign diff_limb_o     = diff_rd;
  assign negative_o      = stat.negative;
  assign result_length_o = stat.length;
  assign end_of_result_o = stat.last;

endmodule

// ===== hw/rtl/dlbs_checker.sv =====
// Port level checks for the decimal limb subtractor, bound to the top level.
module dlbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       last_limb_i,
  input logic       valid_o,
  input logic       negative_o,
  input logic [6:0] result_length_o,
  input logic       end_of_result_o
);

  // The last pair of an operand always starts a busy computation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_limb_i) |=> busy)
    else $error("last pair did not start a computation");

  // Result items only appear while the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result item while not busy");

  // Items of one answer come in consecutive cycles with a steady sign and length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !end_of_result_o) |=>
      (valid_o && $stable(negative_o) && $stable(result_length_o)))
    else $error("answer interrupted or its sign or length changed");

  // The block goes idle right after the last item of an answer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && end_of_result_o) |=> (!valid_o && !busy))
    else $error("block did not go idle after the last item");

  // A reported length never falls outside one to the memory depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((result_length_o != 7'd0) && (result_length_o <= 7'd64)))
    else $error("result length out of range");

endmodule

bind decimal_limb_bignum_subtract_unit dlbs_checker u_dlbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .last_limb_i    (last_limb_i),
  .valid_o        (valid_o),
  .negative_o     (negative_o),
  .result_length_o(result_length_o),
  .end_of_result_o(end_of_result_o)
);
